### rtl/core/cdeq_pkg.sv
package cdeq_pkg;

	localparam int CAPACITY = 16;
	localparam int PTR_W    = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int DATA_W   = 32;
	localparam int OP_W     = 3;
	localparam int STATUS_W = 2;
	localparam int COUNT_W  = 5;

	localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd0;
	localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd1;
	localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
	localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd3;

	localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

	typedef logic [PTR_W-1:0]         ptr_t;
	typedef logic [CNT_W-1:0]         cnt_t;
	typedef logic signed [DATA_W-1:0] data_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		data_t               front_value;
		data_t               back_value;
		logic [COUNT_W-1:0]  count;
		logic                is_empty;
	} res_t;

	function automatic ptr_t slot_next(input ptr_t i);
		return (i == PTR_W'(CAPACITY - 1)) ? '0 : ptr_t'(i + 1'b1);
	endfunction

	function automatic ptr_t slot_prev(input ptr_t i);
		return (i == '0) ? PTR_W'(CAPACITY - 1) : ptr_t'(i - 1'b1);
	endfunction

	// An empty queue reports all ones for both ends.
	function automatic res_t make_res(input logic [STATUS_W-1:0] st, input data_t f,
			input data_t b, input cnt_t c);
		res_t r;
		r.status      = st;
		r.is_empty    = (c == '0);
		r.front_value = r.is_empty ? '1 : f;
		r.back_value  = r.is_empty ? '1 : b;
		r.count       = COUNT_W'(c);
		return r;
	endfunction

endpackage

### rtl/core/cdeq_ifs.sv
interface cdeq_req_if
	import cdeq_pkg::*;
();
	logic            valid;
	logic            ready;
	logic [OP_W-1:0] operation;
	data_t           data;

	modport source (output valid, output operation, output data, input ready);
	modport sink   (input valid, input operation, input data, output ready);
endinterface

interface cdeq_rsp_if
	import cdeq_pkg::*;
();
	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	data_t               front_value;
	data_t               back_value;
	logic [COUNT_W-1:0]  count;
	logic                is_empty;

	modport source (output valid, output status, output front_value, output back_value,
		output count, output is_empty, input ready);
	modport sink   (input valid, input status, input front_value, input back_value,
		input count, input is_empty, output ready);
endinterface

### rtl/core/cdeq_ram.sv
module cdeq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

### rtl/core/cdeq_ctrl.sv
module cdeq_ctrl
	import cdeq_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_ready,
	input  logic [OP_W-1:0] req_op,
	input  data_t           req_data,
	output logic            res_valid,
	output res_t            res,
	input  logic            res_take,
	output logic            ram_we,
	output ptr_t            ram_waddr,
	output data_t           ram_wdata,
	output logic            ram_re,
	output ptr_t            ram_raddr,
	input  data_t           ram_rdata
);
	localparam logic S_IDLE  = 1'b0;
	localparam logic S_FETCH = 1'b1;

	logic  state_q;
	logic  side_front_q;
	ptr_t  head_q, tail_q;
	cnt_t  cnt_q;
	data_t front_q, back_q;
	logic  res_valid_q;
	res_t  res_q;

	logic                acc;
	logic [STATUS_W-1:0] nxt_status;
	ptr_t                nxt_head, nxt_tail;
	cnt_t                nxt_cnt;
	data_t               nxt_front, nxt_back;
	logic                need_fetch;
	logic                is_pop_front;
	data_t               fetch_front, fetch_back;

	assign req_ready = (state_q == S_IDLE) && (!res_valid_q || res_take);
	assign acc       = req_valid && req_ready;

	always_comb begin
		nxt_status   = ST_DONE;
		nxt_head     = head_q;
		nxt_tail     = tail_q;
		nxt_cnt      = cnt_q;
		nxt_front    = front_q;
		nxt_back     = back_q;
		ram_we       = 1'b0;
		ram_waddr    = tail_q;
		ram_wdata    = req_data;
		ram_re       = 1'b0;
		ram_raddr    = slot_next(head_q);
		need_fetch   = 1'b0;
		is_pop_front = 1'b0;
		unique case (req_op) inside
			OP_PUSH_BACK, OP_PUSH_FRONT: begin
				if (cnt_q == CNT_W'(CAPACITY)) begin
					nxt_status = ST_FULL;
				end else begin
					ram_we  = acc;
					nxt_cnt = cnt_q + 1'b1;
					if (req_op == OP_PUSH_BACK) begin
						ram_waddr = tail_q;
						nxt_tail  = slot_next(tail_q);
						nxt_back  = req_data;
						if (cnt_q == '0) begin
							nxt_front = req_data;
						end
					end else begin
						nxt_head  = slot_prev(head_q);
						ram_waddr = nxt_head;
						nxt_front = req_data;
						if (cnt_q == '0) begin
							nxt_back = req_data;
						end
					end
				end
			end
			OP_POP_FRONT, OP_POP_BACK: begin
				if (cnt_q == '0) begin
					nxt_status = ST_EMPTY;
				end else begin
					nxt_cnt      = cnt_q - 1'b1;
					need_fetch   = (nxt_cnt != '0);
					ram_re       = acc && need_fetch;
					is_pop_front = (req_op == OP_POP_FRONT);
					if (is_pop_front) begin
						nxt_head  = slot_next(head_q);
						ram_raddr = nxt_head;
					end else begin
						nxt_tail  = slot_prev(tail_q);
						ram_raddr = slot_prev(nxt_tail);
					end
				end
			end
			default: begin
			end
		endcase
	end

	// The fresh end value arrives from the store in the cycle after the pop.
	assign fetch_front = side_front_q ? ram_rdata : front_q;
	assign fetch_back  = side_front_q ? back_q : ram_rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			side_front_q <= 1'b0;
			head_q       <= '0;
			tail_q       <= '0;
			cnt_q        <= '0;
			res_valid_q  <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (acc) begin
						head_q <= nxt_head;
						tail_q <= nxt_tail;
						cnt_q  <= nxt_cnt;
						if (need_fetch) begin
							state_q      <= S_FETCH;
							side_front_q <= is_pop_front;
							res_valid_q  <= 1'b0;
						end else begin
							res_valid_q <= 1'b1;
						end
					end else if (res_take) begin
						res_valid_q <= 1'b0;
					end
				end
				S_FETCH: begin
					state_q     <= S_IDLE;
					res_valid_q <= 1'b1;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_FETCH) begin
			front_q <= fetch_front;
			back_q  <= fetch_back;
			res_q   <= make_res(ST_DONE, fetch_front, fetch_back, cnt_q);
		end else if (acc) begin
			front_q <= nxt_front;
			back_q  <= nxt_back;
			res_q   <= make_res(nxt_status, nxt_front, nxt_back, nxt_cnt);
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

	a_ptr_match_when_idle_or_full: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == '0 || cnt_q == CNT_W'(CAPACITY)) |-> (head_q == tail_q))
		else $error("pointers disagree with an empty or full count");
	a_ptr_differ_when_partial: assert property (@(posedge clk) disable iff (!arst_n)
		(head_q != tail_q) |-> (cnt_q != '0 && cnt_q != CNT_W'(CAPACITY)))
		else $error("pointers differ but count is empty or full");
	a_no_rw_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(ram_we && ram_re))
		else $error("store written and read in the same cycle");
	a_fetch_follows_pop: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && need_fetch) |=> (state_q == S_FETCH && !res_valid_q))
		else $error("pop did not wait for the store read");
	a_fetch_completes: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FETCH) |=> (state_q == S_IDLE && res_valid_q))
		else $error("store read did not yield a result");
endmodule

### rtl/core/circular_double_ended_queue_core.sv
// Result path: a push, a rejected request or an unlisted opcode reaches rsp via the result
// register and then the output register; a pop that leaves the queue non-empty also
// passes FETCH, the new end value being read via the store RAM's single registered port.
// Throughput: one request per cycle while rsp accepts results, except a pop that leaves
// the queue non-empty, which holds the request side while the store is read.
// Reset: arst_n clears the pointers, the count and all valid flags; store contents are
// left as they are and are only read after a push has written them.
module circular_double_ended_queue_core
	import cdeq_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	cdeq_req_if.sink    req,
	cdeq_rsp_if.source  rsp
);
	// Results of the controller and the RAM port between them.
	logic  res_valid;
	res_t  res;
	logic  res_take;
	logic  ram_we;
	ptr_t  ram_waddr;
	data_t ram_wdata;
	logic  ram_re;
	ptr_t  ram_raddr;
	logic [DATA_W-1:0] ram_rdata;

	// Output register: it frees the controller's result stage whenever it is empty or
	// the downstream side takes its contents, so a new request can be accepted while a
	// finished result still waits on rsp.
	logic out_valid_q;
	res_t out_q;

	assign res_take = res_valid && (!out_valid_q || rsp.ready);

	cdeq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.req_op    (req.operation),
		.req_data  (req.data),
		.res_valid (res_valid),
		.res       (res),
		.res_take  (res_take),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.ram_re    (ram_re),
		.ram_raddr (ram_raddr),
		.ram_rdata (data_t'(ram_rdata))
	);

	// The circular store itself: one write port for pushes, one read port that
	// fetches the element that becomes the new front or back after a pop.
	cdeq_ram #(
		.WIDTH (DATA_W),
		.DEPTH (CAPACITY)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_take) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take) begin
			out_q <= res;
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.status      = out_q.status;
	assign rsp.front_value = out_q.front_value;
	assign rsp.back_value  = out_q.back_value;
	assign rsp.count       = out_q.count;
	assign rsp.is_empty    = out_q.is_empty;
endmodule
